// File: hdl/mrp_pkg.sv
// Shared types and constants for the MRP PDU format checker.
// Depends on nothing; the checker top level imports it.
package mrp_pkg;

    // Frame and field geometry.
    localparam int MAX_FRAME_BYTES = 2048;
    localparam int OFFSET_W        = $clog2(MAX_FRAME_BYTES);
    localparam int COUNT_W         = 13;
    localparam int REMAIN_W        = 12;
    localparam int LEAVE_ALL_SHIFT = 5;
    localparam int LEAVE_ALL_MAX   = 1;

    // Reciprocal of three for (count + 2) / 3 with count below 2^13.
    localparam int RECIP3_SHIFT = 16;
    localparam logic [14:0] RECIP3 = 15'd21846;

    // Register indexes and reset values.
    localparam logic CFG_END_MARK   = 1'b0;
    localparam logic CFG_MAX_PACKED = 1'b1;
    localparam logic [7:0] MAX_PACKED_RESET = 8'd215;

    // Parse phases.
    typedef enum logic [3:0] {
        PH_VERSION = 4'd0,
        PH_MH0     = 4'd1,
        PH_MH1     = 4'd2,
        PH_AH0     = 4'd3,
        PH_AH1     = 4'd4,
        PH_BODY    = 4'd5,
        PH_AE0     = 4'd6,
        PH_AE1     = 4'd7,
        PH_ME0     = 4'd8,
        PH_ME1     = 4'd9,
        PH_DONE    = 4'd10,
        PH_ERR     = 4'd11
    } t_phase;

    // Result status codes.
    typedef enum logic [3:0] {
        ST_OK             = 4'd0,
        ST_TYPE_ZERO      = 4'd1,
        ST_LEN_ZERO       = 4'd2,
        ST_MSG_HDR_SHORT  = 4'd3,
        ST_ATTR_HDR_SHORT = 4'd4,
        ST_LEAVEALL_RSVD  = 4'd5,
        ST_COUNT_ZERO     = 4'd6,
        ST_VALUE_SHORT    = 4'd7,
        ST_VECTOR_SHORT   = 4'd8,
        ST_PACKED_RSVD    = 4'd9
    } t_status;

endpackage

// File: hdl/mrp_pdu_format_checker_unit.sv
// Top level of the MRP PDU format checker: byte parser and result register.
// Depends on mrp_pkg for phases, status codes and frame constants.

// The checker takes one PDU payload word per clock, back to back, and walks
// the version byte, message headers, vector attribute headers, first values
// and packed-event bytes in a single registered pass. Each accepted word is
// decided in the cycle it arrives; the word flagged as last produces one
// result word (status and offset of the failing field) in the result
// register on the next cycle. Input stalls only while that result register
// is full and the receiver is stalling it, so apart from those stalls the
// sustained rate is one word per cycle.
module mrp_pdu_format_checker_unit
    import mrp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration writes
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    // Input words
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    // Result words
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [3:0]          o_status_code,
    output logic [10:0]         o_error_offset
);

    // Configuration registers
    logic [15:0]         r_end_mark;
    logic [7:0]          r_max_packed;

    // Parser state
    t_phase              r_phase,       n_phase;
    logic [OFFSET_W-1:0] r_byte_off,    n_byte_off;
    logic [OFFSET_W-1:0] r_field_start, n_field_start;
    logic [7:0]          r_attr_len,    n_attr_len;
    logic [REMAIN_W-1:0] r_remaining,   n_remaining;
    logic [REMAIN_W-1:0] r_body_cnt,    n_body_cnt;
    logic [7:0]          r_held,        n_held;
    logic                r_rsvd_seen,   n_rsvd_seen;
    t_status             r_latched,     n_latched;

    // Result register
    logic                r_out_valid;
    t_status             r_status,      n_status;
    logic [OFFSET_W-1:0] r_offset,      n_offset;

    logic                accept;
    logic [COUNT_W-1:0]  count;
    logic [COUNT_W:0]    count_rnd;
    logic [28:0]         count_prod;
    logic [REMAIN_W-1:0] vec_bytes;
    logic                end_hit;

    assign o_in_stall     = r_out_valid & i_out_stall;
    assign accept         = i_in_valid & ~o_in_stall;
    assign o_out_valid    = r_out_valid;
    assign o_status_code  = r_status;
    assign o_error_offset = r_offset;

    // Number of packed-event bytes: ceil(count / 3) by reciprocal multiply.
    assign count      = {r_held[COUNT_W-9:0], i_data_byte};
    assign count_rnd  = {1'b0, count} + (COUNT_W+1)'(2);
    assign count_prod = 29'(count_rnd) * 29'(RECIP3);
    assign vec_bytes  = count_prod[RECIP3_SHIFT +: REMAIN_W];
    assign end_hit    = ({r_held, i_data_byte} == r_end_mark);

    // Next parser state for the current word.
    always_comb begin
        logic do_msg;
        logic do_attr;
        do_msg        = 1'b0;
        do_attr       = 1'b0;
        n_phase       = r_phase;
        n_field_start = r_field_start;
        n_attr_len    = r_attr_len;
        n_remaining   = r_remaining;
        n_body_cnt    = r_body_cnt;
        n_held        = r_held;
        n_rsvd_seen   = r_rsvd_seen;
        n_latched     = r_latched;

        case (r_phase)
            PH_VERSION: begin
                n_phase = PH_MH0;
            end
            PH_MH0: begin
                n_held        = i_data_byte;
                n_field_start = r_byte_off;
                n_phase       = PH_MH1;
            end
            PH_AH0: begin
                n_held        = i_data_byte;
                n_field_start = r_byte_off;
                n_phase       = PH_AH1;
            end
            PH_AE0: begin
                n_held        = i_data_byte;
                n_field_start = r_byte_off;
                n_phase       = PH_AE1;
            end
            PH_ME0: begin
                n_held        = i_data_byte;
                n_field_start = r_byte_off;
                n_phase       = PH_ME1;
            end
            PH_MH1: begin
                do_msg = 1'b1;
            end
            PH_AH1: begin
                do_attr = 1'b1;
            end
            PH_AE1: begin
                if (end_hit) begin
                    n_phase = PH_ME0;
                end else begin
                    do_attr = 1'b1;
                end
            end
            PH_ME1: begin
                if (end_hit) begin
                    n_phase = PH_DONE;
                end else begin
                    do_msg = 1'b1;
                end
            end
            PH_BODY: begin
                // Bytes past the first value are packed events.
                if (r_body_cnt >= REMAIN_W'(r_attr_len) && i_data_byte > r_max_packed) begin
                    n_rsvd_seen = 1'b1;
                end
                n_body_cnt  = r_body_cnt + REMAIN_W'(1);
                n_remaining = r_remaining - REMAIN_W'(1);
                if (r_remaining == REMAIN_W'(1)) begin
                    if (n_rsvd_seen) begin
                        n_field_start = r_field_start + OFFSET_W'(r_attr_len);
                        n_latched     = ST_PACKED_RSVD;
                        n_phase       = PH_ERR;
                    end else begin
                        n_phase = PH_AE0;
                    end
                end
            end
            default: begin
            end
        endcase

        // Message header: attribute type, attribute length.
        if (do_msg) begin
            if (r_held == 8'd0) begin
                n_latched = ST_TYPE_ZERO;
                n_phase   = PH_ERR;
            end else if (i_data_byte == 8'd0) begin
                n_latched = ST_LEN_ZERO;
                n_phase   = PH_ERR;
            end else begin
                n_attr_len = i_data_byte;
                n_phase    = PH_AH0;
            end
        end

        // Vector attribute header: leave-all and number of values.
        if (do_attr) begin
            if ((r_held >> LEAVE_ALL_SHIFT) > 8'(LEAVE_ALL_MAX)) begin
                n_latched = ST_LEAVEALL_RSVD;
                n_phase   = PH_ERR;
            end else if (count == '0) begin
                n_latched = ST_COUNT_ZERO;
                n_phase   = PH_ERR;
            end else begin
                n_remaining   = REMAIN_W'(r_attr_len) + vec_bytes;
                n_body_cnt    = '0;
                n_rsvd_seen   = 1'b0;
                n_field_start = r_byte_off + OFFSET_W'(1);
                n_phase       = PH_BODY;
            end
        end

        n_byte_off = r_byte_off;
        if (r_byte_off < OFFSET_W'(MAX_FRAME_BYTES - 1)) begin
            n_byte_off = r_byte_off + OFFSET_W'(1);
        end
    end

    // Result for a final word, taken from the state after that word.
    always_comb begin
        n_status = ST_OK;
        n_offset = n_field_start;
        case (n_phase)
            PH_ERR:  n_status = n_latched;
            PH_MH1:  n_status = ST_MSG_HDR_SHORT;
            PH_AH1:  n_status = ST_ATTR_HDR_SHORT;
            PH_BODY: begin
                if (n_body_cnt < REMAIN_W'(n_attr_len)) begin
                    n_status = ST_VALUE_SHORT;
                end else begin
                    n_status = ST_VECTOR_SHORT;
                    n_offset = n_field_start + OFFSET_W'(n_attr_len);
                end
            end
            default: n_status = ST_OK;
        endcase
        if (n_status == ST_OK) begin
            n_offset = '0;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_mark   <= '0;
            r_max_packed <= MAX_PACKED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_END_MARK:   r_end_mark   <= i_cfg_data;
                CFG_MAX_PACKED: r_max_packed <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Parser control state; a final word returns the frame to its start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_VERSION;
            r_byte_off <= '0;
            r_latched  <= ST_OK;
        end else if (accept) begin
            if (i_last_byte) begin
                r_phase    <= PH_VERSION;
                r_byte_off <= '0;
                r_latched  <= ST_OK;
            end else begin
                r_phase    <= n_phase;
                r_byte_off <= n_byte_off;
                r_latched  <= n_latched;
            end
        end
    end

    // Parser datapath.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_field_start <= n_field_start;
            r_attr_len    <= n_attr_len;
            r_remaining   <= n_remaining;
            r_body_cnt    <= n_body_cnt;
            r_held        <= n_held;
            r_rsvd_seen   <= n_rsvd_seen;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_last_byte) begin
            r_status <= n_status;
            r_offset <= n_offset;
        end
    end

    // A final word always sends the parser back to the version byte.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last_byte |=> r_phase == PH_VERSION && r_byte_off == '0)
        else $error("parser not cleared after final word");

    // The error phase always carries a nonzero latched code.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_ERR |-> r_latched != ST_OK)
        else $error("error phase without latched code");

    // A good frame reports offset zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == ST_OK |-> r_offset == '0)
        else $error("nonzero offset on good frame");

    // The version byte phase is only seen at frame start.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_VERSION |-> r_byte_off == '0)
        else $error("version phase away from frame start");

endmodule
